### src/gsfc_pkg.sv
`default_nettype none

package gsfc_pkg;

    // CRC-8 parameters: MSB first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // Data bytes ahead of the CRC byte; the position counter reaches this value
    localparam logic [2:0] DATA_BYTES = 3'd4;

    // Resistance is reported in tenths
    localparam logic [31:0] RES_SCALE = 32'd10;

    // Reading kinds, sampled with the first byte of a frame
    localparam logic [1:0] KIND_CONC = 2'd0;
    localparam logic [1:0] KIND_RES  = 2'd1;

    typedef enum logic [1:0] {
        FRAME_OK        = 2'd0,
        FRAME_CRC_ERR   = 2'd1,
        FRAME_NOT_READY = 2'd2
    } frame_status_t;

    // One decoded frame
    typedef struct packed {
        logic [7:0]    status_byte;
        logic [7:0]    computed_crc;
        logic [31:0]   reading_value;
        frame_status_t frame_status;
    } frame_result_t;

    // Advance the CRC by one byte, eight bit steps
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'd0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/gsfc_frame_core.sv
`default_nettype none

module gsfc_frame_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,
    input  wire logic [1:0]             s_tuser,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output gsfc_pkg::frame_result_t     res_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [1:0] in_kind_reg;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] frame_reg, frame_next;
    logic [1:0]  kind_reg, kind_next;

    logic        last_byte;
    logic        advance;
    logic [7:0]  crc_base;
    logic [31:0] frame_base;
    logic [31:0] res_value;

    // Hold the byte in the input register until the frame logic takes it
    assign last_byte = (pos_reg == gsfc_pkg::DATA_BYTES);
    assign advance   = in_valid_reg && (!last_byte || res_ready);
    assign s_tready  = !in_valid_reg || advance;
    assign res_valid = in_valid_reg && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
    end

    // Accumulate CRC and data bytes; restart after the CRC byte
    always_comb begin
        crc_base   = (pos_reg == 3'd0) ? gsfc_pkg::CRC_INIT : crc_reg;
        frame_base = (pos_reg == 3'd0) ? 32'd0 : frame_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        frame_next = frame_reg;
        kind_next  = kind_reg;
        if (advance) begin
            if (last_byte) begin
                pos_next = 3'd0;
                crc_next = gsfc_pkg::CRC_INIT;
            end else begin
                pos_next   = pos_reg + 3'd1;
                crc_next   = gsfc_pkg::crc_feed(crc_base, in_byte_reg);
                frame_next = {frame_base[23:0], in_byte_reg};
                if (pos_reg == 3'd0) begin
                    kind_next = in_kind_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            crc_reg   <= gsfc_pkg::CRC_INIT;
            frame_reg <= 32'd0;
            kind_reg  <= 2'd0;
        end else begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            frame_reg <= frame_next;
            kind_reg  <= kind_next;
        end
    end

    // Check the CRC byte and decode the reading
    always_comb begin
        res_value = 32'd0;
        if (crc_reg != in_byte_reg) begin
            res_data.frame_status = gsfc_pkg::FRAME_CRC_ERR;
        end else if (kind_reg == gsfc_pkg::KIND_CONC) begin
            if (frame_reg[24]) begin
                res_data.frame_status = gsfc_pkg::FRAME_NOT_READY;
            end else begin
                res_data.frame_status = gsfc_pkg::FRAME_OK;
                res_value = {8'd0, frame_reg[23:0]};
            end
        end else if (kind_reg == gsfc_pkg::KIND_RES) begin
            res_data.frame_status = gsfc_pkg::FRAME_OK;
            res_value = {8'd0, frame_reg[31:8]} * gsfc_pkg::RES_SCALE;
        end else begin
            res_data.frame_status = gsfc_pkg::FRAME_OK;
            res_value = frame_reg;
        end
        res_data.reading_value = res_value;
        res_data.computed_crc  = crc_reg;
        res_data.status_byte   = frame_reg[31:24];
    end

endmodule

`default_nettype wire

### src/gsfc_out_stage.sv
`default_nettype none

module gsfc_out_stage (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   res_valid,
    output logic                        res_ready,
    input  wire gsfc_pkg::frame_result_t res_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [47:0]                 m_tdata,
    output logic [1:0]                  m_tuser
);

    logic                    valid_reg;
    gsfc_pkg::frame_result_t data_reg;

    // Take a new result when the register is empty or being drained
    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            data_reg <= res_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.status_byte, data_reg.computed_crc, data_reg.reading_value};
    assign m_tuser  = data_reg.frame_status;

endmodule

`default_nettype wire

### src/gas_sensor_frame_checker.sv
// Sensor read-response checker.
// Input stream: one response byte per item on s_tdata, reading kind on s_tuser
// (0 concentration, 1 resistance, 2 version), sampled with the first byte of a frame.
// Every fifth byte closes a frame and yields one item on the output stream:
// m_tuser carries the frame status (0 ok, 1 CRC mismatch, 2 sensor not ready),
// m_tdata the decoded value, the computed CRC-8 and the status byte.
// Bytes one to four produce no output.
// Throughput: one byte per cycle while no finished frame waits for room; the CRC-8
// byte update is combinational between the input register and the frame state.
// A result reaches m_tvalid through the input register, which takes its fifth byte,
// and then the output register, which takes the result once it has room.
// Reset (aresetn low, synchronous) empties both registers and restarts the frame
// at its first byte with the CRC at 0xFF.
// When m_tready is low the output register holds its item; the input register still
// takes data bytes, and stalls s_tready only when a finished frame has no room.

`default_nettype none

module gas_sensor_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] reading_kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [31:0] reading_value, [39:32] computed_crc,
                                        // [47:40] status_byte
    output logic [1:0]       m_tuser    // [1:0] frame_status
);

    logic                    res_valid;
    logic                    res_ready;
    gsfc_pkg::frame_result_t res_data;

    gsfc_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    gsfc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
